FILE: hdl/hcb_pkg.sv
// Shared constants, codes and control bundles for the Huffman code builder.
// No dependencies; used by every module under hdl.
package hcb_pkg;

  localparam int SYMBOLS_DEF   = 256;
  localparam int COUNT_W_DEF   = 32;
  localparam int MAX_CODE_DEF  = 64;
  localparam int WEIGHT_W      = 40;
  localparam int SYM_W         = 8;
  localparam int TABLE_DEPTH   = 256;
  localparam int OP_W          = 2;
  localparam int COUNT_PORT_W  = 32;
  localparam int LEN_PORT_W    = 7;
  localparam int BITS_PORT_W   = 64;
  localparam int LEAF_PORT_W   = 9;
  localparam int HEIGHT_PORT_W = 6;
  localparam int HEIGHT_MAX    = 63;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic node_we;
    logic node_re;
    logic next_we;
    logic next_re;
  } node_ctrl_t;

  typedef struct packed {
    logic clear;
    logic wr_en;
    logic rd_en;
  } code_ctrl_t;

  function automatic logic [WEIGHT_W-1:0] sat_add(input logic [WEIGHT_W-1:0] a,
                                                  input logic [WEIGHT_W-1:0] b);
    logic [WEIGHT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WEIGHT_W] ? {WEIGHT_W{1'b1}} : s[WEIGHT_W-1:0];
  endfunction

endpackage

FILE: hdl/hcb_node_store.sv
// Node pool memory (weight, children, leaf symbol) and list link memory.
// Depends on hcb_pkg; one write and one registered read per memory a cycle.
module hcb_node_store #(
  parameter int NODES = 2 * hcb_pkg::SYMBOLS_DEF - 1,
  parameter int IW    = $clog2(NODES + 1)
) (
  input  logic                         clk,
  input  hcb_pkg::node_ctrl_t          ctrl,
  input  logic [IW-1:0]                node_waddr,
  input  logic [hcb_pkg::WEIGHT_W-1:0] node_wweight,
  input  logic [IW-1:0]                node_wleft,
  input  logic [IW-1:0]                node_wright,
  input  logic [hcb_pkg::SYM_W-1:0]    node_wsym,
  input  logic [IW-1:0]                node_raddr,
  output logic [hcb_pkg::WEIGHT_W-1:0] node_rweight,
  output logic [IW-1:0]                node_rleft,
  output logic [IW-1:0]                node_rright,
  output logic [hcb_pkg::SYM_W-1:0]    node_rsym,
  input  logic [IW-1:0]                next_waddr,
  input  logic [IW-1:0]                next_wdata,
  input  logic [IW-1:0]                next_raddr,
  output logic [IW-1:0]                next_rdata
);

  typedef struct packed {
    logic [hcb_pkg::WEIGHT_W-1:0] weight;
    logic [IW-1:0]                left;
    logic [IW-1:0]                right;
    logic [hcb_pkg::SYM_W-1:0]    sym;
  } node_t;

  node_t         node_mem [NODES];
  logic [IW-1:0] next_mem [NODES];
  node_t         node_q;

  always_ff @(posedge clk) begin
    if (ctrl.node_we) begin
      node_mem[node_waddr] <= '{weight: node_wweight, left: node_wleft,
                                right: node_wright, sym: node_wsym};
    end
    if (ctrl.node_re) begin
      node_q <= node_mem[node_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (ctrl.next_re) begin
      next_rdata <= next_mem[next_raddr];
    end
  end

  assign node_rweight = node_q.weight;
  assign node_rleft   = node_q.left;
  assign node_rright  = node_q.right;
  assign node_rsym    = node_q.sym;

endmodule

FILE: hdl/hcb_code_table.sv
// Per-symbol code table: presence flags in flops, length and bits in memory.
// Depends on hcb_pkg; reads are registered, clear drops every presence flag.
module hcb_code_table #(
  parameter int CODE_W = hcb_pkg::MAX_CODE_DEF,
  parameter int DW     = $clog2(CODE_W + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hcb_pkg::code_ctrl_t       ctrl,
  input  logic [hcb_pkg::SYM_W-1:0] wr_sym,
  input  logic [DW-1:0]             wr_len,
  input  logic [CODE_W-1:0]         wr_bits,
  input  logic [hcb_pkg::SYM_W-1:0] rd_sym,
  output logic                      rd_present,
  output logic [DW-1:0]             rd_len,
  output logic [CODE_W-1:0]         rd_bits
);

  logic [hcb_pkg::TABLE_DEPTH-1:0] present_r;
  logic [DW+CODE_W-1:0]            code_mem [hcb_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= '0;
      rd_present <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        present_r <= '0;
      end else if (ctrl.wr_en) begin
        present_r[wr_sym] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        rd_present <= present_r[rd_sym];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      code_mem[wr_sym] <= {wr_len, wr_bits};
    end
    if (ctrl.rd_en) begin
      {rd_len, rd_bits} <= code_mem[rd_sym];
    end
  end

endmodule

FILE: hdl/huffman_code_builder.sv
// Huffman code builder top level: sequencer, walk stack memory, result register.
// Depends on hcb_pkg, hcb_node_store and hcb_code_table.
//
//   channel | direction | payload
//   in_     | sink      | opcode, symbol, count
//   out_    | source    | result_kind, status, leaf_count, tree_height, code_symbol,
//           |           | present, code_length, code_bits
//
// Load: writes a leaf node and links it into the weight-ordered list by walking its links.
// Build: merges the two lightest entries while more than one remains, then walks the tree.
// Query: reads the code table. Node and link memory reads are registered.
// Reset empties the list; code table presence flags clear at once, no sweep.
// A finished result waits in the output register while the next beat is taken;
// a second result holds the sequencer until the first has moved on.
module huffman_code_builder #(
  parameter int SYMBOLS       = hcb_pkg::SYMBOLS_DEF,
  parameter int COUNT_WIDTH   = hcb_pkg::COUNT_W_DEF,
  parameter int MAX_CODE_BITS = hcb_pkg::MAX_CODE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_symbol,
  input  logic [31:0] in_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic        out_status,
  output logic [8:0]  out_leaf_count,
  output logic [5:0]  out_tree_height,
  output logic [7:0]  out_code_symbol,
  output logic        out_present,
  output logic [6:0]  out_code_length,
  output logic [63:0] out_code_bits
);

  localparam int NODES = 2 * SYMBOLS - 1;
  localparam int IW    = $clog2(NODES + 1);
  localparam int DW    = $clog2(MAX_CODE_BITS + 1);
  localparam int LW    = $clog2(SYMBOLS + 1);
  localparam int WW    = hcb_pkg::WEIGHT_W;
  localparam int SW    = hcb_pkg::SYM_W;
  localparam int CW    = MAX_CODE_BITS;
  localparam logic [IW-1:0] NIL = IW'(NODES);

  typedef enum logic [4:0] {
    S_IDLE, S_INS_START, S_INS_HEAD, S_INS_NEXT, S_INS_CMP, S_LINK1, S_LINK2,
    S_B_LOOP, S_B_POPA, S_B_POPB, S_B_MAKE,
    S_W_POP, S_W_ENT, S_W_NODE, S_W_PUSHL, S_EMIT
  } state_t;

  typedef struct packed {
    logic [IW-1:0] node;
    logic [DW-1:0] depth;
    logic [CW-1:0] code;
    logic [IW-1:0] td;
  } stk_t;

  state_t        state_r;
  logic [IW-1:0] head_r, len_r, used_r, ins_n_r, cur_r, nx_r, link_r, a_r, b_r, sp_r;
  logic [LW-1:0] leaves_r;
  logic [WW-1:0] ins_w_r, wa_r, w_r;
  logic          to_head_r, ins_build_r;
  logic          kind_r, status_r;
  logic [LW-1:0] rep_leaves_r;
  logic [IW-1:0] height_r;
  logic [SW-1:0] qsym_r;
  stk_t          left_ent_r, ent_r;

  hcb_pkg::node_ctrl_t nctl;
  hcb_pkg::code_ctrl_t cctl;
  logic [IW-1:0] node_waddr, node_wleft, node_wright, node_raddr;
  logic [WW-1:0] node_wweight, node_rweight;
  logic [SW-1:0] node_wsym, node_rsym, code_rsym;
  logic [IW-1:0] node_rleft, node_rright;
  logic [IW-1:0] next_waddr, next_wdata, next_raddr, next_rdata;
  logic          code_present;
  logic [DW-1:0] code_len;
  logic [CW-1:0] code_bits;

  stk_t          stk_mem [NODES];
  stk_t          stk_rd, stk_wdata;
  logic          stk_we, stk_re;
  logic [IW-1:0] stk_waddr, stk_raddr;

  logic          accept, load_ok, node_leaf, push_ok;
  logic [WW-1:0] cnt_w;
  stk_t          right_ent, left_ent;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign cnt_w    = WW'(in_count[COUNT_WIDTH-1:0]);
  assign load_ok  = (cnt_w != '0) && (leaves_r < LW'(SYMBOLS)) && (used_r < NIL);
  assign node_leaf = (node_rleft == NIL);
  assign push_ok  = ({1'b0, sp_r} + (IW+1)'(2)) <= (IW+1)'(NODES);

  always_comb begin
    right_ent.node = node_rright;
    left_ent.node  = node_rleft;
    right_ent.td   = ent_r.td + IW'(1);
    left_ent.td    = ent_r.td + IW'(1);
    if (ent_r.depth < DW'(MAX_CODE_BITS)) begin
      right_ent.code  = {ent_r.code[CW-2:0], 1'b1};
      left_ent.code   = {ent_r.code[CW-2:0], 1'b0};
      right_ent.depth = ent_r.depth + DW'(1);
      left_ent.depth  = ent_r.depth + DW'(1);
    end else begin
      right_ent.code  = ent_r.code;
      left_ent.code   = ent_r.code;
      right_ent.depth = ent_r.depth;
      left_ent.depth  = ent_r.depth;
    end
  end

  always_comb begin
    nctl         = '0;
    cctl         = '0;
    node_waddr   = used_r;
    node_wweight = w_r;
    node_wleft   = a_r;
    node_wright  = b_r;
    node_wsym    = '0;
    node_raddr   = head_r;
    next_waddr   = ins_n_r;
    next_wdata   = link_r;
    next_raddr   = head_r;
    code_rsym    = in_symbol;
    stk_we       = 1'b0;
    stk_re       = 1'b0;
    stk_waddr    = sp_r;
    stk_raddr    = sp_r - IW'(1);
    stk_wdata    = right_ent;
    case (state_r)
      S_IDLE: begin
        if (accept && in_opcode == hcb_pkg::OP_QUERY) begin
          cctl.rd_en = 1'b1;
        end
        if (accept && in_opcode == hcb_pkg::OP_BUILD) begin
          cctl.clear = 1'b1;
        end
        if (accept && in_opcode == hcb_pkg::OP_LOAD && load_ok) begin
          nctl.node_we = 1'b1;
          node_wweight = cnt_w;
          node_wleft   = NIL;
          node_wright  = NIL;
          node_wsym    = in_symbol;
        end
      end
      S_INS_START: begin
        nctl.node_re = (head_r != NIL);
      end
      S_INS_HEAD: begin
        nctl.next_re = !(ins_w_r < node_rweight);
      end
      S_INS_NEXT: begin
        nctl.node_re = (next_rdata != NIL);
        node_raddr   = next_rdata;
      end
      S_INS_CMP: begin
        nctl.next_re = (node_rweight <= ins_w_r);
        next_raddr   = nx_r;
      end
      S_LINK1: begin
        nctl.next_we = 1'b1;
      end
      S_LINK2: begin
        nctl.next_we = 1'b1;
        next_waddr   = cur_r;
        next_wdata   = ins_n_r;
      end
      S_B_LOOP: begin
        if (len_r > IW'(1) && used_r < NIL) begin
          nctl.node_re = 1'b1;
          nctl.next_re = 1'b1;
        end else begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = '{node: head_r, depth: '0, code: '0, td: '0};
        end
      end
      S_B_POPA: begin
        nctl.node_re = 1'b1;
        nctl.next_re = 1'b1;
        node_raddr   = next_rdata;
        next_raddr   = next_rdata;
      end
      S_B_MAKE: begin
        nctl.node_we = 1'b1;
      end
      S_W_POP: begin
        stk_re = (sp_r != '0);
      end
      S_W_ENT: begin
        nctl.node_re = 1'b1;
        node_raddr   = stk_rd.node;
      end
      S_W_NODE: begin
        if (node_leaf) begin
          cctl.wr_en = 1'b1;
        end else if (push_ok) begin
          stk_we = 1'b1;
        end
      end
      S_W_PUSHL: begin
        stk_we    = 1'b1;
        stk_waddr = sp_r + IW'(1);
        stk_wdata = left_ent_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      head_r          <= NIL;
      len_r           <= '0;
      used_r          <= '0;
      leaves_r        <= '0;
      out_valid       <= 1'b0;
      out_result_kind <= 1'b0;
      out_status      <= 1'b0;
      out_leaf_count  <= '0;
      out_tree_height <= '0;
      out_code_symbol <= '0;
      out_present     <= 1'b0;
      out_code_length <= '0;
      out_code_bits   <= '0;
    end else begin
      if (out_valid && out_ready && state_r != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_opcode)
              hcb_pkg::OP_LOAD: begin
                if (load_ok) begin
                  ins_n_r     <= used_r;
                  ins_w_r     <= cnt_w;
                  used_r      <= used_r + IW'(1);
                  leaves_r    <= leaves_r + LW'(1);
                  ins_build_r <= 1'b0;
                  state_r     <= S_INS_START;
                end
              end
              hcb_pkg::OP_BUILD: begin
                kind_r       <= hcb_pkg::KIND_REPORT;
                rep_leaves_r <= leaves_r;
                height_r     <= '0;
                if (len_r == '0) begin
                  status_r <= hcb_pkg::STATUS_EMPTY;
                  head_r   <= NIL;
                  used_r   <= '0;
                  leaves_r <= '0;
                  state_r  <= S_EMIT;
                end else begin
                  status_r <= hcb_pkg::STATUS_OK;
                  state_r  <= S_B_LOOP;
                end
              end
              hcb_pkg::OP_QUERY: begin
                kind_r  <= hcb_pkg::KIND_QUERY;
                qsym_r  <= in_symbol;
                state_r <= S_EMIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_INS_START: begin
          if (head_r == NIL) begin
            link_r    <= NIL;
            to_head_r <= 1'b1;
            state_r   <= S_LINK1;
          end else begin
            state_r <= S_INS_HEAD;
          end
        end
        S_INS_HEAD: begin
          if (ins_w_r < node_rweight) begin
            link_r    <= head_r;
            to_head_r <= 1'b1;
            state_r   <= S_LINK1;
          end else begin
            cur_r     <= head_r;
            to_head_r <= 1'b0;
            state_r   <= S_INS_NEXT;
          end
        end
        S_INS_NEXT: begin
          nx_r <= next_rdata;
          if (next_rdata == NIL) begin
            link_r  <= NIL;
            state_r <= S_LINK1;
          end else begin
            state_r <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (node_rweight <= ins_w_r) begin
            cur_r   <= nx_r;
            state_r <= S_INS_NEXT;
          end else begin
            link_r  <= nx_r;
            state_r <= S_LINK1;
          end
        end
        S_LINK1: begin
          if (to_head_r) begin
            head_r  <= ins_n_r;
            len_r   <= len_r + IW'(1);
            state_r <= ins_build_r ? S_B_LOOP : S_IDLE;
          end else begin
            state_r <= S_LINK2;
          end
        end
        S_LINK2: begin
          len_r   <= len_r + IW'(1);
          state_r <= ins_build_r ? S_B_LOOP : S_IDLE;
        end
        S_B_LOOP: begin
          if (len_r > IW'(1) && used_r < NIL) begin
            a_r     <= head_r;
            state_r <= S_B_POPA;
          end else begin
            sp_r    <= IW'(1);
            state_r <= S_W_POP;
          end
        end
        S_B_POPA: begin
          wa_r    <= node_rweight;
          b_r     <= next_rdata;
          head_r  <= next_rdata;
          state_r <= S_B_POPB;
        end
        S_B_POPB: begin
          w_r     <= hcb_pkg::sat_add(wa_r, node_rweight);
          head_r  <= next_rdata;
          len_r   <= len_r - IW'(2);
          state_r <= S_B_MAKE;
        end
        S_B_MAKE: begin
          ins_n_r     <= used_r;
          ins_w_r     <= w_r;
          used_r      <= used_r + IW'(1);
          ins_build_r <= 1'b1;
          state_r     <= S_INS_START;
        end
        S_W_POP: begin
          if (sp_r == '0) begin
            head_r   <= NIL;
            len_r    <= '0;
            used_r   <= '0;
            leaves_r <= '0;
            state_r  <= S_EMIT;
          end else begin
            sp_r    <= sp_r - IW'(1);
            state_r <= S_W_ENT;
          end
        end
        S_W_ENT: begin
          ent_r   <= stk_rd;
          state_r <= S_W_NODE;
        end
        S_W_NODE: begin
          if (node_leaf) begin
            if (ent_r.td > height_r) begin
              height_r <= ent_r.td;
            end
            state_r <= S_W_POP;
          end else if (push_ok) begin
            left_ent_r <= left_ent;
            state_r    <= S_W_PUSHL;
          end else begin
            state_r <= S_W_POP;
          end
        end
        S_W_PUSHL: begin
          sp_r    <= sp_r + IW'(2);
          state_r <= S_W_POP;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            out_result_kind <= kind_r;
            if (kind_r == hcb_pkg::KIND_QUERY) begin
              out_status      <= hcb_pkg::STATUS_OK;
              out_leaf_count  <= '0;
              out_tree_height <= '0;
              out_code_symbol <= qsym_r;
              out_present     <= code_present;
              out_code_length <= code_present ? 7'(code_len) : '0;
              out_code_bits   <= code_present ? 64'(code_bits) : '0;
            end else begin
              out_status      <= status_r;
              out_leaf_count  <= 9'(rep_leaves_r);
              out_tree_height <= (height_r > IW'(hcb_pkg::HEIGHT_MAX)) ?
                                 6'(hcb_pkg::HEIGHT_MAX) : 6'(height_r);
              out_code_symbol <= '0;
              out_present     <= 1'b0;
              out_code_length <= '0;
              out_code_bits   <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  hcb_node_store #(.NODES(NODES), .IW(IW)) u_node_store (
    .clk          (clk),
    .ctrl         (nctl),
    .node_waddr   (node_waddr),
    .node_wweight (node_wweight),
    .node_wleft   (node_wleft),
    .node_wright  (node_wright),
    .node_wsym    (node_wsym),
    .node_raddr   (node_raddr),
    .node_rweight (node_rweight),
    .node_rleft   (node_rleft),
    .node_rright  (node_rright),
    .node_rsym    (node_rsym),
    .next_waddr   (next_waddr),
    .next_wdata   (next_wdata),
    .next_raddr   (next_raddr),
    .next_rdata   (next_rdata)
  );

  hcb_code_table #(.CODE_W(CW), .DW(DW)) u_code_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (cctl),
    .wr_sym     (node_rsym),
    .wr_len     (ent_r.depth),
    .wr_bits    (ent_r.code),
    .rd_sym     (code_rsym),
    .rd_present (code_present),
    .rd_len     (code_len),
    .rd_bits    (code_bits)
  );

  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == hcb_pkg::KIND_REPORT && out_status == hcb_pkg::STATUS_EMPTY
    |-> out_leaf_count == '0 && out_tree_height == '0)
    else $error("empty build report carries a tree");

  a_absent_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == hcb_pkg::KIND_QUERY && !out_present
    |-> out_code_length == '0 && out_code_bits == '0)
    else $error("absent symbol answers with a code");

  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= used_r && used_r <= NIL)
    else $error("list longer than node pool");

endmodule
